>>> src/tbrl_pkg.sv
// ----------------------------------------------------------------------------
// tbrl_pkg: shared constants for the token bucket rate limiter
// Register map codes, Q1.16 constants, reset values and divider sizing.
// ----------------------------------------------------------------------------
package tbrl_pkg;

  localparam int HISTORY_DEPTH_DEF = 9;

  localparam logic [16:0] ONE_Q16 = 17'd65536;
  localparam logic [62:0] MASK63  = {63{1'b1}};

  localparam logic [31:0] MAX_TOKENS_RST   = 32'd100;
  localparam logic [31:0] TOKENS_REF_RST   = 32'd1;
  localparam logic [62:0] REFRESH_IVL_RST  = 63'd10000000;
  localparam logic [31:0] PERIOD_LEN_RST   = 32'd1000000000;

  // shared restoring divider: 64-bit dividend, one quotient bit per cycle
  localparam int DIV_W = 64;
  localparam logic [6:0] DIV_STEPS = 7'd64;

  typedef enum logic [1:0] {
    REG_MAX_TOKENS  = 2'd0,
    REG_TOKENS_REF  = 2'd1,
    REG_REFRESH_IVL = 2'd2,
    REG_PERIOD_LEN  = 2'd3
  } cfg_reg_t;

endpackage

>>> src/token_bucket_rate_limiter_core.sv
// ----------------------------------------------------------------------------
// token_bucket_rate_limiter_core: token bucket limiter with rate statistics
// Refills a token bucket per elapsed interval, grants or refuses requests and
// reports the mean allow ratio over a period history and the current period.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake          | payload
//  s_*      | in  | s_tvalid/s_tready  | s_tdata: timestamp, req_tokens
//  m_*      | out | m_tvalid/m_tready  | m_tdata: allowed, mean_rate
//  apb      | in  | psel/penable/pready| paddr, pwdata, prdata (64 bit)
//
// Each word is worked on alone, with a 9-entry history by default: a shared
// bit-serial divider performs each division (period index twice, current
// ratio, mean; closed ratio on a period change with requests, refill count
// when a refill is due), between control states and, on a period change,
// history shift steps.
// s_tready is high only while no word is in work. A finished result waits in
// the output register; the next word is taken meanwhile. Synchronous reset.
// ----------------------------------------------------------------------------
module token_bucket_rate_limiter_core
  import tbrl_pkg::*;
#(
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [95:0] s_tdata,   // [62:0] timestamp, [94:63] req_tokens
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [0] allowed, [17:1] mean_rate
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  localparam int TOTAL_W = $clog2(HISTORY_DEPTH * 65536 + 1);
  localparam int SC_W    = $clog2(HISTORY_DEPTH + 2);
  localparam logic [TOTAL_W-1:0] TOTAL_RST = TOTAL_W'(HISTORY_DEPTH * 65536);
  localparam logic [SC_W-1:0]    SHIFT_MAX = SC_W'(HISTORY_DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_NOW, S_START, S_CLOSED, S_SHIFT, S_COUNT,
    S_REFILL, S_ADD, S_GRANT, S_CUR_L, S_CUR, S_RATE, S_DONE
  } state_t;

  state_t state, ret;

  logic [31:0] bucket_cap, refill_tokens, period_length;
  logic [62:0] refresh_interval;

  logic [31:0] token_count;
  logic [62:0] next_refresh_time, period_start;
  logic [31:0] requests_in_period, allowed_in_period;
  logic [16:0] ratio_history [HISTORY_DEPTH];
  logic [TOTAL_W-1:0] history_total;

  logic [62:0] ts, ts_rem, now_idx;
  logic [31:0] req;
  logic [16:0] ins, rate;
  logic [SC_W-1:0] shift_cnt;
  logic [63:0] prod;
  logic        grant;

  logic [DIV_W-1:0] div_quo, div_rem, div_den;
  logic [6:0]       div_cnt;

  logic [DIV_W-1:0] div_trial;
  logic             div_fit;
  logic [63:0]      per_eff, ivl_eff;
  logic             cfg_wr;
  logic [62:0]      k_val;
  logic [63:0]      n_val, next_val;
  logic [64:0]      sum_val;
  logic [16:0]      quo_sat;
  logic [TOTAL_W:0] mean_num;

  assign div_trial = {div_rem[DIV_W-2:0], div_quo[DIV_W-1]};
  assign div_fit   = div_trial >= div_den;
  assign per_eff   = (period_length == 32'd0) ? 64'd1 : 64'(period_length);
  assign ivl_eff   = (refresh_interval == 63'd0) ? 64'd1 : 64'(refresh_interval);
  assign cfg_wr    = psel && penable && pwrite && pready;
  assign k_val     = now_idx - div_quo[62:0];
  assign n_val     = div_quo + 64'd1;
  assign next_val  = 64'(ts) - div_rem + ivl_eff;
  assign sum_val   = 65'(token_count) + 65'(prod);
  assign quo_sat   = (div_quo > 64'(ONE_Q16)) ? ONE_Q16 : div_quo[16:0];
  assign mean_num  = (TOTAL_W+1)'(history_total) + (TOTAL_W+1)'(quo_sat);

  assign s_tready = (state == S_IDLE);
  assign pready   = 1'b1;

  always_comb begin
    unique case (cfg_reg_t'(paddr[4:3]))
      REG_MAX_TOKENS:  prdata = 64'(bucket_cap);
      REG_TOKENS_REF:  prdata = 64'(refill_tokens);
      REG_REFRESH_IVL: prdata = 64'(refresh_interval);
      REG_PERIOD_LEN:  prdata = 64'(period_length);
      default:         prdata = 64'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= S_IDLE;
      ret                <= S_IDLE;
      bucket_cap         <= MAX_TOKENS_RST;
      refill_tokens      <= TOKENS_REF_RST;
      refresh_interval   <= REFRESH_IVL_RST;
      period_length      <= PERIOD_LEN_RST;
      token_count        <= MAX_TOKENS_RST;
      next_refresh_time  <= REFRESH_IVL_RST;
      period_start       <= 63'd0;
      requests_in_period <= 32'd0;
      allowed_in_period  <= 32'd0;
      history_total      <= TOTAL_RST;
      for (int i = 0; i < HISTORY_DEPTH; i++) ratio_history[i] <= ONE_Q16;
      m_tvalid           <= 1'b0;
      div_cnt            <= 7'd0;
      shift_cnt          <= '0;
    end else begin
      if (m_tvalid && m_tready && state != S_DONE) m_tvalid <= 1'b0;

      if (cfg_wr) begin
        unique case (cfg_reg_t'(paddr[4:3]))
          REG_MAX_TOKENS: begin
            bucket_cap  <= pwdata[31:0];
            token_count <= pwdata[31:0];
          end
          REG_TOKENS_REF: refill_tokens <= pwdata[31:0];
          REG_REFRESH_IVL: begin
            refresh_interval  <= pwdata[62:0];
            next_refresh_time <= pwdata[62:0];
          end
          REG_PERIOD_LEN: period_length <= pwdata[31:0];
          default: ;
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            ts      <= s_tdata[62:0];
            req     <= s_tdata[94:63];
            div_quo <= 64'(s_tdata[62:0]);
            div_rem <= '0;
            div_den <= per_eff;
            div_cnt <= DIV_STEPS;
            ret     <= S_NOW;
            state   <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_cnt != 7'd0) begin
            div_rem <= div_fit ? div_trial - div_den : div_trial;
            div_quo <= {div_quo[DIV_W-2:0], div_fit};
            div_cnt <= div_cnt - 7'd1;
          end else begin
            state <= ret;
          end
        end
        S_NOW: begin
          now_idx <= div_quo[62:0];
          ts_rem  <= div_rem[62:0];
          div_quo <= 64'(period_start);
          div_rem <= '0;
          div_den <= per_eff;
          div_cnt <= DIV_STEPS;
          ret     <= S_START;
          state   <= S_DIV;
        end
        S_START: begin
          if (now_idx > div_quo[62:0]) begin
            // shifting past the whole history plus one leaves only 1.0 entries
            shift_cnt    <= (k_val > 63'(HISTORY_DEPTH + 1)) ? SHIFT_MAX
                                                             : k_val[SC_W-1:0];
            period_start <= ts - ts_rem;
            if (requests_in_period == 32'd0) begin
              ins   <= ONE_Q16;
              state <= S_SHIFT;
            end else begin
              div_quo <= {16'd0, allowed_in_period, 16'd0};
              div_rem <= '0;
              div_den <= 64'(requests_in_period);
              div_cnt <= DIV_STEPS;
              ret     <= S_CLOSED;
              state   <= S_DIV;
            end
          end else begin
            state <= S_COUNT;
          end
        end
        S_CLOSED: begin
          ins   <= quo_sat;
          state <= S_SHIFT;
        end
        S_SHIFT: begin
          if (shift_cnt != '0) begin
            ratio_history[0] <= ins;
            for (int i = 1; i < HISTORY_DEPTH; i++)
              ratio_history[i] <= ratio_history[i-1];
            history_total <= history_total - TOTAL_W'(ratio_history[HISTORY_DEPTH-1])
                             + TOTAL_W'(ins);
            ins       <= ONE_Q16;
            shift_cnt <= shift_cnt - SC_W'(1);
          end else begin
            requests_in_period <= 32'd0;
            allowed_in_period  <= 32'd0;
            state              <= S_COUNT;
          end
        end
        S_COUNT: begin
          if (requests_in_period != 32'hFFFF_FFFF)
            requests_in_period <= requests_in_period + 32'd1;
          if (ts >= next_refresh_time) begin
            div_quo <= 64'(ts - next_refresh_time);
            div_rem <= '0;
            div_den <= ivl_eff;
            div_cnt <= DIV_STEPS;
            ret     <= S_REFILL;
            state   <= S_DIV;
          end else begin
            state <= S_GRANT;
          end
        end
        S_REFILL: begin
          // n intervals end at ts - remainder + interval
          next_refresh_time <= next_val[63] ? MASK63 : next_val[62:0];
          if (n_val[63:32] != 32'd0) begin
            if (refill_tokens != 32'd0) token_count <= bucket_cap;
            state <= S_GRANT;
          end else begin
            prod  <= 64'(n_val[31:0]) * 64'(refill_tokens);
            state <= S_ADD;
          end
        end
        S_ADD: begin
          token_count <= (sum_val > 65'(bucket_cap)) ? bucket_cap : sum_val[31:0];
          state       <= S_GRANT;
        end
        S_GRANT: begin
          grant <= (token_count >= req);
          if (token_count >= req) begin
            token_count <= token_count - req;
            if (allowed_in_period != 32'hFFFF_FFFF)
              allowed_in_period <= allowed_in_period + 32'd1;
          end
          state <= S_CUR_L;
        end
        S_CUR_L: begin
          div_quo <= {16'd0, allowed_in_period, 16'd0};
          div_rem <= '0;
          div_den <= 64'(requests_in_period);
          div_cnt <= DIV_STEPS;
          ret     <= S_CUR;
          state   <= S_DIV;
        end
        S_CUR: begin
          div_quo <= 64'(mean_num);
          div_rem <= '0;
          div_den <= 64'(HISTORY_DEPTH + 1);
          div_cnt <= DIV_STEPS;
          ret     <= S_RATE;
          state   <= S_DIV;
        end
        S_RATE: begin
          rate  <= div_quo[16:0];
          state <= S_DONE;
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= {6'd0, rate, grant};
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> sim/token_bucket_rate_limiter_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// token_bucket_rate_limiter_core_test: self-checking bench for the limiter
// Drives timestamped token requests over the stream input and programs the
// bucket over APB between phases. A bit-accurate grant/rate predictor runs
// on every accepted request, and each output word is checked in order.
// ----------------------------------------------------------------------------
module token_bucket_rate_limiter_core_test;
  import tbrl_pkg::*;

  localparam int DEPTH = HISTORY_DEPTH_DEF;
  localparam int STALL_LIMIT = 20000;
  localparam logic [63:0] ALL32 = 64'hFFFF_FFFF;

  typedef struct packed {
    logic [62:0] stamp;
    logic [31:0] want;
  } request_t;

  typedef struct packed {
    logic        grant;
    logic [16:0] rate;
  } verdict_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [95:0] s_tdata = '0;   // [62:0] timestamp, [94:63] req_tokens
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;        // [0] allowed, [17:1] mean_rate
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;

  token_bucket_rate_limiter_core dut (.*);

  always #5 clk = ~clk;

  // predictor copy of configuration and state
  logic [63:0] cap_tokens, refill_amt, refill_ivl, stat_period;
  logic [63:0] bucket, next_refill, period_base;
  logic [31:0] req_cnt, grant_cnt;
  logic [16:0] ratio_hist [DEPTH];
  int unsigned hist_sum;

  request_t    pending_reqs[$];
  verdict_t    expected_verdicts[$];
  int          mismatches = 0;
  int          words_in = 0, words_out = 0, grants_seen = 0;
  int          idle_cycles = 0;
  bit          quiet = 1'b0;
  bit          word_taken = 1'b0;
  logic [63:0] clock_now = 0;

  function automatic logic [16:0] q16_ratio(logic [31:0] num, logic [31:0] den);
    logic [63:0] r;
    if (den == 0) return ONE_Q16;
    r = {num, 16'h0} / den;
    return (r > ONE_Q16) ? ONE_Q16 : r[16:0];
  endfunction

  function automatic verdict_t predict_grant(logic [62:0] stamp, logic [31:0] want);
    logic [63:0] per, ivl, now_idx, base_idx, gap, n, nxt, sum;
    logic [16:0] closed;
    int          sh;
    verdict_t    v;
    per = (stat_period != 0) ? stat_period : 64'd1;
    ivl = (refill_ivl != 0) ? refill_ivl : 64'd1;
    now_idx = stamp / per;
    base_idx = period_base / per;
    if (now_idx > base_idx) begin
      gap = now_idx - base_idx;
      closed = q16_ratio(grant_cnt, req_cnt);
      if (gap < DEPTH) begin
        sh = int'(gap);
        for (int i = DEPTH - 1; i >= sh; i--) ratio_hist[i] = ratio_hist[i - sh];
      end
      for (int i = 0; i < DEPTH; i++) begin
        if (64'(i) + 1 < gap) ratio_hist[i] = ONE_Q16;
        else if (64'(i) + 1 == gap) ratio_hist[i] = closed;
      end
      hist_sum = 0;
      for (int i = 0; i < DEPTH; i++) hist_sum += ratio_hist[i];
      req_cnt = 0;
      grant_cnt = 0;
      period_base = now_idx * per;
    end
    if (req_cnt != 32'hFFFF_FFFF) req_cnt++;
    if (64'(stamp) >= next_refill) begin
      n = (64'(stamp) - next_refill) / ivl + 1;
      nxt = next_refill + ivl * n;
      next_refill = (nxt > 64'(MASK63)) ? 64'(MASK63) : nxt;
      if (n > ALL32) begin
        if (refill_amt != 0) bucket = cap_tokens;
      end else begin
        sum = bucket + n * refill_amt;
        bucket = (sum > cap_tokens) ? cap_tokens : sum;
      end
    end
    v.grant = 1'b0;
    if (bucket >= 64'(want)) begin
      v.grant = 1'b1;
      if (grant_cnt != 32'hFFFF_FFFF) grant_cnt++;
      bucket -= 64'(want);
    end
    v.rate = 17'((64'(hist_sum) + 64'(q16_ratio(grant_cnt, req_cnt))) / (DEPTH + 1));
    return v;
  endfunction

  task automatic reg_write(cfg_reg_t idx, logic [63:0] val);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= 5'(idx) << 3; pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    case (idx)
      REG_MAX_TOKENS:  begin cap_tokens = val & ALL32; bucket = cap_tokens; end
      REG_TOKENS_REF:  refill_amt = val & ALL32;
      REG_REFRESH_IVL: begin refill_ivl = val & 64'(MASK63); next_refill = refill_ivl; end
      default:         stat_period = val & ALL32;
    endcase
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic push_req(logic [63:0] stamp, logic [63:0] want);
    request_t r;
    r.stamp = stamp[62:0];
    r.want = want[31:0];
    pending_reqs.push_back(r);
  endtask

  task automatic drain();
    wait (pending_reqs.size() == 0 && !s_tvalid && expected_verdicts.size() == 0);
    @(negedge clk);
  endtask

  task automatic random_phase(int count);
    logic [63:0] per, step, want;
    int          pick;
    per = (stat_period != 0) ? stat_period : 64'd1;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) step = 64'($urandom_range(0, 64));
      else if (pick < 85) step = {$urandom, $urandom} % (2 * per + 1);
      else if (pick < 95) step = {$urandom, $urandom} % (12 * per + 1);
      else step = {$urandom, $urandom} >> $urandom_range(0, 20);
      clock_now = (clock_now + step > 64'(MASK63)) ? 64'(MASK63) : clock_now + step;
      pick = $urandom_range(0, 9);
      if (pick == 0) want = 0;
      else if (pick == 1) want = 64'($urandom);
      else want = 64'($urandom_range(0, 40));
      push_req(clock_now, want);
    end
    drain();
  endtask

  // stimulus and phase control
  initial begin
    cap_tokens = 64'(MAX_TOKENS_RST); refill_amt = 64'(TOKENS_REF_RST);
    refill_ivl = 64'(REFRESH_IVL_RST); stat_period = 64'(PERIOD_LEN_RST);
    bucket = cap_tokens; next_refill = refill_ivl; period_base = 0;
    req_cnt = 0; grant_cnt = 0;
    for (int i = 0; i < DEPTH; i++) ratio_hist[i] = ONE_Q16;
    hist_sum = DEPTH * 65536;
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // directed: reset settings, zero and full requests, empty bucket, refill
    push_req(0, 0);
    push_req(0, ALL32);
    push_req(5, 60);
    push_req(9, 41);
    push_req(10, 40);
    push_req(10000000, 1);
    push_req(29999999, 2);
    push_req(999999999, 0);
    push_req(1000000000, 50);          // next period
    push_req(1000000001, 80);
    push_req(64'd4500000000, 10);      // skipped periods
    push_req(64'd4500000000, 0);
    push_req(64'd30000000000, 1);      // gap longer than the history
    push_req(64'd20000000000, 1);      // time going backwards
    drain();
    clock_now = 64'd30000000000;

    // zero interval and zero period act as one; refill count past 32 bits
    reg_write(REG_MAX_TOKENS, 50);
    reg_write(REG_TOKENS_REF, 3);
    reg_write(REG_REFRESH_IVL, 0);
    reg_write(REG_PERIOD_LEN, 0);
    push_req(clock_now + 1, 50);
    push_req(clock_now + 2, 4);
    push_req(clock_now + 2, 3);
    push_req(clock_now + 64'h2_0000_0000, 50);
    push_req(clock_now + 64'h2_0000_0000, 1);
    drain();
    clock_now += 64'h2_0000_0000;

    // extremes of the settings
    reg_write(REG_MAX_TOKENS, ALL32);
    reg_write(REG_TOKENS_REF, ALL32);
    reg_write(REG_REFRESH_IVL, 64'(MASK63));
    reg_write(REG_PERIOD_LEN, ALL32);
    random_phase(60);

    reg_write(REG_MAX_TOKENS, 0);
    reg_write(REG_REFRESH_IVL, 1);
    reg_write(REG_PERIOD_LEN, 1000);
    random_phase(60);

    for (int ph = 0; ph < 6; ph++) begin
      reg_write(REG_MAX_TOKENS, 64'($urandom_range(0, 300)));
      reg_write(REG_TOKENS_REF, 64'($urandom_range(1, 8)));
      reg_write(REG_REFRESH_IVL, 64'($urandom_range(1, 5000)));
      reg_write(REG_PERIOD_LEN, 64'($urandom_range(1, 200000)));
      random_phase(100);
    end

    // last part without idling, ending at the top of the time range
    quiet = 1'b1;
    reg_write(REG_MAX_TOKENS, 1000);
    reg_write(REG_TOKENS_REF, 2);
    reg_write(REG_REFRESH_IVL, 1000);
    reg_write(REG_PERIOD_LEN, 100000);
    random_phase(70);
    push_req(64'(MASK63), 5);
    push_req(64'(MASK63), 5000);
    push_req(64'(MASK63) - 7, 1);
    drain();
    repeat (500) @(negedge clk);

    $display("covered %0d requests, %0d grants, with zero, extreme and random settings,",
             words_in, grants_seen);
    $display("skipped periods, backward time, refill overflow and output back-pressure");
    if (mismatches == 0 && expected_verdicts.size() == 0) begin
      $display("token_bucket_rate_limiter_core_test passed");
    end else begin
      $display("token_bucket_rate_limiter_core_test failed");
    end
    $finish;
  end

  // request driver
  int send_gap = 0;
  always @(negedge clk) begin
    logic nv;
    nv = s_tvalid;
    if (word_taken) begin
      void'(pending_reqs.pop_front());
      nv = 1'b0;
    end
    if (send_gap > 0) send_gap--;
    else if (!quiet && $urandom_range(0, 15) == 0) send_gap = $urandom_range(1, 10);
    if (!nv && !rst && send_gap == 0 && pending_reqs.size() > 0) begin
      nv = 1'b1;
      s_tdata <= {1'b0, pending_reqs[0].want, pending_reqs[0].stamp};
    end
    s_tvalid <= nv;
  end

  // result receiver with one long hold-off
  int  recv_gap = 0;
  bit  long_hold_done = 1'b0;
  always @(negedge clk) begin
    if (!long_hold_done && words_in >= 300) begin
      long_hold_done = 1'b1;
      recv_gap = 3000;
    end
    if (recv_gap > 0) recv_gap--;
    else if (!quiet && $urandom_range(0, 15) == 0) recv_gap = $urandom_range(1, 10);
    m_tready <= (recv_gap == 0) && !rst;
  end

  // monitor, checker and watchdog
  always @(posedge clk) begin
    verdict_t exp_v, got_v;
    bit       active;
    active = psel && penable;
    word_taken = s_tvalid && s_tready;
    if (word_taken) begin
      expected_verdicts.push_back(predict_grant(s_tdata[62:0], s_tdata[94:63]));
      words_in++;
      active = 1'b1;
    end
    if (m_tvalid && m_tready) begin
      active = 1'b1;
      got_v.grant = m_tdata[0];
      got_v.rate = m_tdata[17:1];
      words_out++;
      if (got_v.grant) grants_seen++;
      if (expected_verdicts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected output word %h", m_tdata);
      end else begin
        exp_v = expected_verdicts.pop_front();
        if (exp_v.grant !== got_v.grant || exp_v.rate !== got_v.rate) begin
          mismatches++;
          if (mismatches <= 10)
            $display("word %0d: expected allowed=%0d rate=%0d, got allowed=%0d rate=%0d",
                     words_out, exp_v.grant, exp_v.rate, got_v.grant, got_v.rate);
        end
      end
    end
    idle_cycles = active ? 0 : idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("token_bucket_rate_limiter_core_test failed");
      $finish;
    end
  end

endmodule

>>> token_bucket_rate_limiter_core.f
src/tbrl_pkg.sv
src/token_bucket_rate_limiter_core.sv
sim/token_bucket_rate_limiter_core_test.sv
